// ----- src/ctbr_pkg.sv -----
// ----------------------------------------------------------------------------
// ctbr_pkg
// shared types and constants for the transceiver bus-off recovery block
// ----------------------------------------------------------------------------
package ctbr_pkg;

  localparam logic [1:0] FUNC_SET    = 2'd0;
  localparam logic [1:0] FUNC_NOTIFY = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_QUERY  = 2'd3;

  localparam logic [2:0] REG_DELAY_FAST   = 3'd0;
  localparam logic [2:0] REG_DELAY_MEDIUM = 3'd1;
  localparam logic [2:0] REG_DELAY_SLOW   = 3'd2;
  localparam logic [2:0] REG_DELAY_MAX    = 3'd3;

  localparam logic [15:0] DELAY_FAST_RST   = 16'd100;
  localparam logic [15:0] DELAY_MEDIUM_RST = 16'd250;
  localparam logic [15:0] DELAY_SLOW_RST   = 16'd500;
  localparam logic [15:0] DELAY_MAX_RST    = 16'd1000;

  localparam logic [7:0]  COUNT_MAX    = 8'hFF;
  localparam logic [31:0] TCOUNT_RST   = 32'd1;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the input word
    logic exec;   // apply a non-tick word to the addressed channel
    logic walk;   // visit one channel of a tick
    logic resp;   // register the result word
  } ctbr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_last;
  } ctbr_sts_t;

endpackage

// ----- src/can_transceiver_busoff_recovery.sv -----
// ----------------------------------------------------------------------------
// can_transceiver_busoff_recovery
// standby pin control with timed bus-off recovery for several transceivers
// ----------------------------------------------------------------------------
// sequence: set, notify and query words pass through an exec step and then the result
//   register before out_stb rises; a tick walks the channels instead, one step per channel
// a new word is taken only while busy is low, once the channel walk and the result
//   register are through with the last word
// reset: synchronous rst_n restores default delays and clears all channel state;
//   results cannot be stalled, out_stb is high for exactly one cycle per word
module can_transceiver_busoff_recovery import ctbr_pkg::*; #(
  parameter int CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [2:0]  in_channel,
  input  logic        in_mode,
  input  logic        in_bus_off,
  input  logic [31:0] in_tick_ms,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_stb,
  output logic        out_ok,
  output logic [7:0]  out_stb_levels,
  output logic        out_applied_mode_out,
  output logic        out_requested_mode_out,
  output logic        out_recovery_active_out,
  output logic [7:0]  out_recovery_count_out,
  output logic [15:0] out_recovery_delay_out,
  output logic [31:0] out_recover_at_out,
  output logic [31:0] out_transition_count_out,
  output logic [31:0] out_last_change_out
);

  ctbr_cmd_t cmd;
  ctbr_sts_t sts;

  // registers must only change while idle; the block itself does not enforce it, so the port is always open
  assign cfg_ready = 1'b1;

  ctbr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  ctbr_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cmd                      (cmd),
    .sts                      (sts),
    .in_func                  (in_func),
    .in_channel               (in_channel),
    .in_mode                  (in_mode),
    .in_bus_off               (in_bus_off),
    .in_tick_ms               (in_tick_ms),
    .cfg_we                   (cfg_valid & cfg_ready),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .out_stb                  (out_stb),
    .out_ok                   (out_ok),
    .out_stb_levels           (out_stb_levels),
    .out_applied_mode_out     (out_applied_mode_out),
    .out_requested_mode_out   (out_requested_mode_out),
    .out_recovery_active_out  (out_recovery_active_out),
    .out_recovery_count_out   (out_recovery_count_out),
    .out_recovery_delay_out   (out_recovery_delay_out),
    .out_recover_at_out       (out_recover_at_out),
    .out_transition_count_out (out_transition_count_out),
    .out_last_change_out      (out_last_change_out)
  );

endmodule

// ----- src/ctbr_ctrl.sv -----
// ----------------------------------------------------------------------------
// ctbr_ctrl
// sequencer: one exec step for commands, one step per channel for ticks
// ----------------------------------------------------------------------------
module ctbr_ctrl import ctbr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_func,
  input  ctbr_sts_t  sts,
  output ctbr_cmd_t  cmd,
  output logic       busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (in_func == FUNC_TICK) ? S_WALK : S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_RESP;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        cmd.resp  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- src/ctbr_dp.sv -----
// ----------------------------------------------------------------------------
// ctbr_dp
// per-channel recovery state, delay registers and result register
// ----------------------------------------------------------------------------
module ctbr_dp import ctbr_pkg::*; #(
  parameter int CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctbr_cmd_t   cmd,
  output ctbr_sts_t   sts,
  input  logic [1:0]  in_func,
  input  logic [2:0]  in_channel,
  input  logic        in_mode,
  input  logic        in_bus_off,
  input  logic [31:0] in_tick_ms,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_stb,
  output logic        out_ok,
  output logic [7:0]  out_stb_levels,
  output logic        out_applied_mode_out,
  output logic        out_requested_mode_out,
  output logic        out_recovery_active_out,
  output logic [7:0]  out_recovery_count_out,
  output logic [15:0] out_recovery_delay_out,
  output logic [31:0] out_recover_at_out,
  output logic [31:0] out_transition_count_out,
  output logic [31:0] out_last_change_out
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

  // delay registers
  logic [15:0] dly_fast_r, dly_medium_r, dly_slow_r, dly_max_r;

  // captured word
  logic [1:0]       func_r;
  logic [2:0]       channel_r;
  logic             mode_r;
  logic             bus_off_r;
  logic [31:0]      tick_r;
  logic [IDX_W-1:0] idx_r;

  // per-channel state
  logic [CHANNELS-1:0] am_r, rm_r, ra_r;
  logic [31:0] rat_r   [CHANNELS];
  logic [15:0] dly_r   [CHANNELS];
  logic [7:0]  cnt_r   [CHANNELS];
  logic [31:0] tcnt_r  [CHANNELS];
  logic [31:0] last_r  [CHANNELS];

  // current channel view
  logic        cur_ra;
  logic [31:0] cur_rat;
  logic [15:0] cur_dly;
  logic [7:0]  cur_cnt;
  logic [31:0] cur_tcnt;
  logic [31:0] arm_sum;
  logic [31:0] diff;
  logic [7:0]  cnt_inc;
  logic [15:0] dly_sel;
  logic        ch_ok;
  logic [7:0]  stb_vec;

  assign cur_ra   = ra_r[idx_r];
  assign cur_rat  = rat_r[idx_r];
  assign cur_dly  = dly_r[idx_r];
  assign cur_cnt  = cnt_r[idx_r];
  assign cur_tcnt = tcnt_r[idx_r];
  assign arm_sum  = tick_r + {16'd0, cur_dly};
  assign diff     = tick_r - cur_rat;
  assign cnt_inc  = (cur_cnt == COUNT_MAX) ? COUNT_MAX : cur_cnt + 8'd1;
  assign ch_ok    = ({1'b0, channel_r} < 4'(CHANNELS));

  always_comb begin
    if (cnt_inc <= 8'd1) begin
      dly_sel = dly_fast_r;
    end else if (cnt_inc == 8'd2) begin
      dly_sel = dly_medium_r;
    end else if (cnt_inc == 8'd3) begin
      dly_sel = dly_slow_r;
    end else begin
      dly_sel = dly_max_r;
    end
  end

  always_comb begin
    stb_vec = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      stb_vec[i] = am_r[i];
    end
  end

  assign sts.walk_last = (idx_r == IDX_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_fast_r   <= DELAY_FAST_RST;
      dly_medium_r <= DELAY_MEDIUM_RST;
      dly_slow_r   <= DELAY_SLOW_RST;
      dly_max_r    <= DELAY_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELAY_FAST:   dly_fast_r   <= cfg_data;
        REG_DELAY_MEDIUM: dly_medium_r <= cfg_data;
        REG_DELAY_SLOW:   dly_slow_r   <= cfg_data;
        REG_DELAY_MAX:    dly_max_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r    <= in_func;
      channel_r <= in_channel;
      mode_r    <= in_mode;
      bus_off_r <= in_bus_off;
      tick_r    <= in_tick_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.load) begin
      idx_r <= (in_func == FUNC_TICK) ? '0 : in_channel[IDX_W-1:0];
    end else if (cmd.walk) begin
      // after the last channel point back at the addressed one for the result
      idx_r <= sts.walk_last ? channel_r[IDX_W-1:0] : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      am_r <= '0;
      rm_r <= '0;
      ra_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        rat_r[i]  <= '0;
        dly_r[i]  <= '0;
        cnt_r[i]  <= '0;
        tcnt_r[i] <= TCOUNT_RST;
        last_r[i] <= '0;
      end
    end else if (cmd.walk) begin
      if (cur_ra) begin
        if (cur_rat == 32'd0) begin
          rat_r[idx_r] <= arm_sum;
        end else if (!diff[31]) begin
          am_r[idx_r]   <= 1'b0;
          rm_r[idx_r]   <= 1'b0;
          ra_r[idx_r]   <= 1'b0;
          rat_r[idx_r]  <= '0;
          last_r[idx_r] <= tick_r;
          tcnt_r[idx_r] <= cur_tcnt + 32'd1;
        end
      end
    end else if (cmd.exec && ch_ok) begin
      case (func_r)
        FUNC_SET: begin
          am_r[idx_r]   <= mode_r;
          rm_r[idx_r]   <= mode_r;
          ra_r[idx_r]   <= 1'b0;
          rat_r[idx_r]  <= '0;
          dly_r[idx_r]  <= '0;
          cnt_r[idx_r]  <= '0;
          tcnt_r[idx_r] <= cur_tcnt + 32'd1;
        end
        FUNC_NOTIFY: begin
          if (bus_off_r) begin
            am_r[idx_r]   <= 1'b1;
            rm_r[idx_r]   <= 1'b0;
            ra_r[idx_r]   <= 1'b1;
            rat_r[idx_r]  <= '0;
            cnt_r[idx_r]  <= cnt_inc;
            dly_r[idx_r]  <= dly_sel;
            tcnt_r[idx_r] <= cur_tcnt + 32'd1;
          end else begin
            ra_r[idx_r]  <= 1'b0;
            rat_r[idx_r] <= '0;
            dly_r[idx_r] <= '0;
            cnt_r[idx_r] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_stb <= 1'b0;
    end else begin
      out_stb <= cmd.resp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      out_ok                   <= ch_ok;
      out_stb_levels           <= stb_vec;
      out_applied_mode_out     <= ch_ok & am_r[idx_r];
      out_requested_mode_out   <= ch_ok & rm_r[idx_r];
      out_recovery_active_out  <= ch_ok & cur_ra;
      out_recovery_count_out   <= ch_ok ? cur_cnt : '0;
      out_recovery_delay_out   <= ch_ok ? cur_dly : '0;
      out_recover_at_out       <= ch_ok ? cur_rat : '0;
      out_transition_count_out <= ch_ok ? cur_tcnt : '0;
      out_last_change_out      <= ch_ok ? last_r[idx_r] : '0;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// drives set, notify, tick and query words into the bus-off recovery block,
// predicts or looks up every status word and compares it field by field as it strobes out
// ----------------------------------------------------------------------------
module tb_top;
  import ctbr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CH = 4;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        ok;
    logic [7:0]  stb_levels;
    logic        applied;
    logic        requested;
    logic        active;
    logic [7:0]  count;
    logic [15:0] delay;
    logic [31:0] recover_at;
    logic [31:0] transitions;
    logic [31:0] last_change;
  } status_t;

  typedef struct {
    logic [1:0]  func;
    logic [2:0]  ch;
    logic        md;
    logic        bo;
    logic [31:0] tick;
    bit          typed;
    status_t     want;
  } word_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_func;
  logic [2:0]  in_channel;
  logic        in_mode;
  logic        in_bus_off;
  logic [31:0] in_tick_ms;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        out_stb;
  logic        out_ok;
  logic [7:0]  out_stb_levels;
  logic        out_applied_mode_out;
  logic        out_requested_mode_out;
  logic        out_recovery_active_out;
  logic [7:0]  out_recovery_count_out;
  logic [15:0] out_recovery_delay_out;
  logic [31:0] out_recover_at_out;
  logic [31:0] out_transition_count_out;
  logic [31:0] out_last_change_out;

  can_transceiver_busoff_recovery #(.CHANNELS(CH)) i_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .start                    (start),
    .busy                     (busy),
    .in_func                  (in_func),
    .in_channel               (in_channel),
    .in_mode                  (in_mode),
    .in_bus_off               (in_bus_off),
    .in_tick_ms               (in_tick_ms),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .out_stb                  (out_stb),
    .out_ok                   (out_ok),
    .out_stb_levels           (out_stb_levels),
    .out_applied_mode_out     (out_applied_mode_out),
    .out_requested_mode_out   (out_requested_mode_out),
    .out_recovery_active_out  (out_recovery_active_out),
    .out_recovery_count_out   (out_recovery_count_out),
    .out_recovery_delay_out   (out_recovery_delay_out),
    .out_recover_at_out       (out_recover_at_out),
    .out_transition_count_out (out_transition_count_out),
    .out_last_change_out      (out_last_change_out)
  );

  // shadow copy of the channel state and delay registers
  logic        sh_applied   [CH];
  logic        sh_requested [CH];
  logic        sh_active    [CH];
  logic [31:0] sh_recover_at[CH];
  logic [15:0] sh_delay     [CH];
  logic [7:0]  sh_count     [CH];
  logic [31:0] sh_trans     [CH];
  logic [31:0] sh_last      [CH];
  logic [15:0] sh_cfg_delay [4];

  status_t     status_pending[$];
  status_t     got_word;
  status_t     want_word;
  word_row_t   directed[$];
  int          errors;
  int          cycles;
  bit          no_idle;
  logic [31:0] now_ms;
  int          step_max;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [15:0] backoff_delay(logic [7:0] n);
    if (n <= 8'd1) return sh_cfg_delay[0];
    if (n == 8'd2) return sh_cfg_delay[1];
    if (n == 8'd3) return sh_cfg_delay[2];
    return sh_cfg_delay[3];
  endfunction

  function automatic void clear_shadow_recovery(int c);
    sh_active[c]     = 1'b0;
    sh_recover_at[c] = '0;
    sh_delay[c]      = '0;
    sh_count[c]      = '0;
  endfunction

  // apply one word to the shadow state and return the status it reports
  function automatic status_t recovery_step(logic [1:0] f, logic [2:0] ch, logic md,
                                            logic bo, logic [31:0] now);
    status_t     r;
    logic        valid;
    logic [31:0] diff;
    int          c;
    valid = (int'(ch) < CH);
    if (f == FUNC_TICK) begin
      for (c = 0; c < CH; c++) begin
        if (sh_active[c]) begin
          if (sh_recover_at[c] == '0) begin
            // a sum that wraps to zero leaves it unarmed for the next tick
            sh_recover_at[c] = now + 32'(sh_delay[c]);
          end else begin
            diff = now - sh_recover_at[c];
            if (!diff[31]) begin
              sh_applied[c]    = 1'b0;
              sh_requested[c]  = 1'b0;
              sh_active[c]     = 1'b0;
              sh_recover_at[c] = '0;
              sh_last[c]       = now;
              sh_trans[c]      = sh_trans[c] + 32'd1;
            end
          end
        end
      end
    end else if (valid && f == FUNC_SET) begin
      sh_applied[ch]   = md;
      sh_requested[ch] = md;
      clear_shadow_recovery(ch);
      sh_trans[ch]     = sh_trans[ch] + 32'd1;
    end else if (valid && f == FUNC_NOTIFY) begin
      if (!bo) begin
        clear_shadow_recovery(ch);
      end else begin
        sh_applied[ch]    = 1'b1;
        sh_requested[ch]  = 1'b0;
        sh_active[ch]     = 1'b1;
        sh_recover_at[ch] = '0;
        if (sh_count[ch] < COUNT_MAX) sh_count[ch] = sh_count[ch] + 8'd1;
        sh_delay[ch]      = backoff_delay(sh_count[ch]);
        sh_trans[ch]      = sh_trans[ch] + 32'd1;
      end
    end
    r = '0;
    r.ok = valid;
    for (c = 0; c < CH; c++) r.stb_levels[c] = sh_applied[c];
    if (valid) begin
      r.applied     = sh_applied[ch];
      r.requested   = sh_requested[ch];
      r.active      = sh_active[ch];
      r.count       = sh_count[ch];
      r.delay       = sh_delay[ch];
      r.recover_at  = sh_recover_at[ch];
      r.transitions = sh_trans[ch];
      r.last_change = sh_last[ch];
    end
    return r;
  endfunction

  function automatic status_t mk_status(logic ok, logic [7:0] stb, logic am, logic rm,
                                        logic ra, logic [7:0] cnt, logic [15:0] dly,
                                        logic [31:0] rat, logic [31:0] tc, logic [31:0] lc);
    status_t s;
    s.ok = ok; s.stb_levels = stb; s.applied = am; s.requested = rm; s.active = ra;
    s.count = cnt; s.delay = dly; s.recover_at = rat; s.transitions = tc;
    s.last_change = lc;
    return s;
  endfunction

  function automatic word_row_t mk_row(logic [1:0] f, logic [2:0] ch, logic md, logic bo,
                                       logic [31:0] tick, bit typed, status_t want);
    word_row_t w;
    w.func = f; w.ch = ch; w.md = md; w.bo = bo; w.tick = tick;
    w.typed = typed; w.want = want;
    return w;
  endfunction

  task automatic send_word(logic [1:0] f, logic [2:0] ch, logic md, logic bo,
                           logic [31:0] tick, bit typed, status_t want);
    int      gap;
    status_t exp_word;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_func    <= f;
    in_channel <= ch;
    in_mode    <= md;
    in_bus_off <= bo;
    in_tick_ms <= tick;
    @(posedge clk);
    while (busy) @(posedge clk);
    exp_word = recovery_step(f, ch, md, bo, tick);
    status_pending.push_back(typed ? want : exp_word);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (status_pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= REG_DELAY_MAX) sh_cfg_delay[idx[1:0]] = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_delays(logic [15:0] fast, logic [15:0] med, logic [15:0] slow,
                            logic [15:0] max_d);
    write_reg(REG_DELAY_FAST, fast);
    write_reg(REG_DELAY_MEDIUM, med);
    write_reg(REG_DELAY_SLOW, slow);
    write_reg(REG_DELAY_MAX, max_d);
    // an index past the last register must be dropped
    write_reg(3'($urandom_range(4, 7)), 16'($urandom));
  endtask

  task automatic run_random(int n);
    int          k;
    int          r;
    logic [1:0]  f;
    logic [2:0]  ch;
    logic [31:0] tick;
    logic        bo;
    for (k = 0; k < n; k++) begin
      r    = $urandom_range(0, 99);
      ch   = ($urandom_range(0, 99) < 8) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
      tick = $urandom;
      bo   = 1'($urandom);
      if (r < 45) begin
        f = FUNC_TICK;
        now_ms = now_ms + 32'($urandom_range(0, step_max));
        if ($urandom_range(0, 31) == 0) now_ms = $urandom;
        tick = now_ms;
      end else if (r < 65) begin
        f = FUNC_NOTIFY; bo = 1'b1;
      end else if (r < 72) begin
        f = FUNC_NOTIFY; bo = 1'b0;
      end else if (r < 83) begin
        f = FUNC_SET;
      end else if (r < 97) begin
        f = FUNC_QUERY;
      end else begin
        f = 2'($urandom);
      end
      send_word(f, ch, 1'($urandom), bo, tick, 1'b0, '0);
    end
  endtask

  // result checking, one status word per strobe
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_stb) begin
      got_word = mk_status(out_ok, out_stb_levels, out_applied_mode_out,
                           out_requested_mode_out, out_recovery_active_out,
                           out_recovery_count_out, out_recovery_delay_out,
                           out_recover_at_out, out_transition_count_out,
                           out_last_change_out);
      if (status_pending.size() == 0) begin
        $display("%0t: unexpected status word, expected none, got %h", $time, got_word);
        errors++;
      end else begin
        want_word = status_pending.pop_front();
        check_field("ok", 32'(want_word.ok), 32'(got_word.ok));
        check_field("stb_levels", 32'(want_word.stb_levels), 32'(got_word.stb_levels));
        check_field("applied_mode", 32'(want_word.applied), 32'(got_word.applied));
        check_field("requested_mode", 32'(want_word.requested), 32'(got_word.requested));
        check_field("recovery_active", 32'(want_word.active), 32'(got_word.active));
        check_field("recovery_count", 32'(want_word.count), 32'(got_word.count));
        check_field("recovery_delay", 32'(want_word.delay), 32'(got_word.delay));
        check_field("recover_at", want_word.recover_at, got_word.recover_at);
        check_field("transition_count", want_word.transitions, got_word.transitions);
        check_field("last_change", want_word.last_change, got_word.last_change);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d status words outstanding", $time,
               status_pending.size());
      $display("** can_transceiver_busoff_recovery: FAILED **");
      $finish;
    end
  end

  initial begin
    int p;
    int k;
    int sat_ch;
    logic [15:0] d[4];
    errors     = 0;
    cycles     = 0;
    no_idle    = 1'b0;
    now_ms     = '0;
    step_max   = 100;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_func    = FUNC_QUERY;
    in_channel = '0;
    in_mode    = 1'b0;
    in_bus_off = 1'b0;
    in_tick_ms = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_DELAY_FAST;
    cfg_data   = '0;
    sh_cfg_delay[0] = DELAY_FAST_RST;
    sh_cfg_delay[1] = DELAY_MEDIUM_RST;
    sh_cfg_delay[2] = DELAY_SLOW_RST;
    sh_cfg_delay[3] = DELAY_MAX_RST;
    for (k = 0; k < CH; k++) begin
      sh_applied[k]   = 1'b0;
      sh_requested[k] = 1'b0;
      clear_shadow_recovery(k);
      sh_trans[k]     = TCOUNT_RST;
      sh_last[k]      = '0;
    end

    // state after reset, invalid channels, first bus-off at default delays
    directed.push_back(mk_row(FUNC_QUERY, 3'd0, 1'b0, 1'b0, 32'd0, 1'b1,
      mk_status(1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 8'd0, 16'd0, 32'd0, TCOUNT_RST, 32'd0)));
    directed.push_back(mk_row(FUNC_QUERY, 3'd7, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, '0));
    directed.push_back(mk_row(FUNC_SET, 3'd4, 1'b1, 1'b1, 32'd0, 1'b1, '0));
    directed.push_back(mk_row(FUNC_NOTIFY, 3'd1, 1'b0, 1'b1, 32'd0, 1'b1,
      mk_status(1'b1, 8'h02, 1'b1, 1'b0, 1'b1, 8'd1, DELAY_FAST_RST, 32'd0,
                TCOUNT_RST + 32'd1, 32'd0)));
    // arming across the wrap, early tick, return on the deadline
    directed.push_back(mk_row(FUNC_TICK, 3'd0, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, '0));
    directed.push_back(mk_row(FUNC_QUERY, 3'd1, 1'b0, 1'b0, 32'd0, 1'b0, '0));
    directed.push_back(mk_row(FUNC_TICK, 3'd3, 1'b1, 1'b1, 32'd50, 1'b0, '0));
    directed.push_back(mk_row(FUNC_TICK, 3'd1, 1'b0, 1'b0, 32'd99, 1'b0, '0));
    directed.push_back(mk_row(FUNC_QUERY, 3'd1, 1'b0, 1'b0, 32'd0, 1'b0, '0));
    directed.push_back(mk_row(FUNC_SET, 3'd2, 1'b1, 1'b0, 32'd0, 1'b0, '0));
    directed.push_back(mk_row(FUNC_SET, 3'd2, 1'b0, 1'b1, 32'd0, 1'b0, '0));
    // backoff through fast, medium, slow and max, then a clear
    for (k = 0; k < 4; k++)
      directed.push_back(mk_row(FUNC_NOTIFY, 3'd3, 1'b0, 1'b1, 32'd0, 1'b0, '0));
    directed.push_back(mk_row(FUNC_NOTIFY, 3'd3, 1'b1, 1'b0, 32'd0, 1'b0, '0));
    // deadline sum of zero stays unarmed, then arms on the next tick
    directed.push_back(mk_row(FUNC_NOTIFY, 3'd0, 1'b0, 1'b1, 32'd0, 1'b0, '0));
    directed.push_back(mk_row(FUNC_TICK, 3'd0, 1'b0, 1'b0, 32'hFFFF_FF9C, 1'b0, '0));
    directed.push_back(mk_row(FUNC_TICK, 3'd0, 1'b0, 1'b0, 32'hFFFF_FF9D, 1'b0, '0));
    directed.push_back(mk_row(FUNC_TICK, 3'd0, 1'b0, 1'b0, 32'd0, 1'b0, '0));
    directed.push_back(mk_row(FUNC_TICK, 3'd0, 1'b0, 1'b0, 32'd1, 1'b0, '0));
    // signed difference at the half-range boundary
    directed.push_back(mk_row(FUNC_NOTIFY, 3'd2, 1'b0, 1'b1, 32'd0, 1'b0, '0));
    directed.push_back(mk_row(FUNC_TICK, 3'd2, 1'b0, 1'b0, 32'd1000, 1'b0, '0));
    directed.push_back(mk_row(FUNC_TICK, 3'd2, 1'b0, 1'b0, 32'h8000_044C, 1'b0, '0));
    directed.push_back(mk_row(FUNC_TICK, 3'd2, 1'b0, 1'b0, 32'h8000_044B, 1'b0, '0));
    directed.push_back(mk_row(FUNC_NOTIFY, 3'd5, 1'b1, 1'b1, 32'd0, 1'b0, '0));
    directed.push_back(mk_row(FUNC_QUERY, 3'd2, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, '0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    foreach (directed[k])
      send_word(directed[k].func, directed[k].ch, directed[k].md, directed[k].bo,
                directed[k].tick, directed[k].typed, directed[k].want);
    drain();

    for (p = 0; p < 7; p++) begin
      case (p)
        0: begin d[0] = 16'd1; d[1] = 16'd1; d[2] = 16'd1; d[3] = 16'd1; end
        1: begin d[0] = 16'hFFFF; d[1] = 16'hFFFF; d[2] = 16'hFFFF; d[3] = 16'hFFFF; end
        2: begin d[0] = 16'd1; d[1] = 16'hFFFF; d[2] = 16'd2; d[3] = 16'd40000; end
        3: begin
          d[0] = DELAY_FAST_RST; d[1] = DELAY_MEDIUM_RST;
          d[2] = DELAY_SLOW_RST; d[3] = DELAY_MAX_RST;
        end
        default: begin
          for (k = 0; k < 4; k++)
            d[k] = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(1, 300))
                                               : 16'($urandom_range(1, 65535));
        end
      endcase
      set_delays(d[0], d[1], d[2], d[3]);
      step_max = 2;
      for (k = 0; k < 4; k++)
        if (int'(d[k]) / 3 + 2 > step_max) step_max = int'(d[k]) / 3 + 2;
      no_idle = (p % 3 == 2);
      if (p == 5) begin
        // drive one channel's bus-off count into saturation
        sat_ch = $urandom_range(0, CH - 1);
        for (k = 0; k < 300; k++) begin
          if ($urandom_range(0, 9) == 0)
            send_word(FUNC_QUERY, 3'(sat_ch), 1'($urandom), 1'($urandom), $urandom,
                      1'b0, '0);
          else
            send_word(FUNC_NOTIFY, 3'(sat_ch), 1'($urandom), 1'b1, $urandom, 1'b0, '0);
        end
      end
      run_random(240);
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("** can_transceiver_busoff_recovery: PASSED **");
    end else begin
      $display("** can_transceiver_busoff_recovery: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/ctbr_pkg.sv
src/ctbr_ctrl.sv
src/ctbr_dp.sv
src/can_transceiver_busoff_recovery.sv
tb/tb_top.sv
